// ===== design/rfdc_pkg.sv =====
// rfdc_pkg: shared types and constants of the ring fifo with drop count
// no dependencies; imported by rfdc_front, rfdc_back and the top level
`timescale 1ns / 1ps

package rfdc_pkg;

  // ring geometry
  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned EVENT_WIDTH = 64;

  // port widths fixed by the item format
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned DROP_W  = 32;

  // pointers run modulo twice the capacity
  localparam int unsigned PTR_W = $clog2(2 * CAPACITY);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_BATCH = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_WRITTEN   = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_DELIVERED = 2'd3
  } status_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_BATCH = 1'b1
  } bk_state_e;

  // command passed from front to back
  typedef struct packed {
    op_e                    op;
    logic [EVENT_WIDTH-1:0] data;
    logic [CNT_W-1:0]       count;
  } cmd_t;

endpackage

// ===== design/rfdc_ram.sv =====
// rfdc_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rfdc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rfdc_front.sv =====
// rfdc_front: accepts request items, turns them into commands, two-entry command queue
// depends on rfdc_pkg
`timescale 1ns / 1ps

module rfdc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rfdc_pkg::REQ_W-1:0] req_type_i,
  input  logic [rfdc_pkg::DATA_W-1:0] event_data_i,
  input  logic [rfdc_pkg::CNT_W-1:0] max_events_i,
  output logic                       cmd_valid_o,
  output rfdc_pkg::cmd_t             cmd_o,
  input  logic                       cmd_pop_i
);
  import rfdc_pkg::*;

  localparam int unsigned QDEPTH = 2;

  cmd_t        q_mem_q [QDEPTH];
  logic        q_wr_q, q_wr_d;
  logic        q_rd_q, q_rd_d;
  logic [1:0]  q_cnt_q, q_cnt_d;
  cmd_t        cmd_new;
  logic        push;
  logic        pop;

  // classify: a single read is a batch of one, unused kind makes no command
  always_comb begin
    cmd_new.data  = event_data_i[EVENT_WIDTH-1:0];
    cmd_new.op    = OP_READ;
    cmd_new.count = max_events_i;
    unique case (req_e'(req_type_i))
      REQ_WRITE: begin
        cmd_new.op    = OP_WRITE;
        cmd_new.count = '0;
      end
      REQ_READ: begin
        cmd_new.count = CNT_W'(1);
      end
      REQ_BATCH, REQ_NONE: begin
        cmd_new.count = max_events_i;
      end
      default: begin
        cmd_new.count = max_events_i;
      end
    endcase
  end

  assign in_ready_o  = (q_cnt_q != 2'(QDEPTH));
  assign push        = in_valid_i && in_ready_o && (req_e'(req_type_i) != REQ_NONE);
  assign cmd_valid_o = (q_cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[q_rd_q];

  // queue pointers and fill
  always_comb begin
    q_wr_d  = push ? ~q_wr_q : q_wr_q;
    q_rd_d  = pop ? ~q_rd_q : q_rd_q;
    q_cnt_d = q_cnt_q;
    if (push && !pop) begin
      q_cnt_d = q_cnt_q + 2'd1;
    end else if (pop && !push) begin
      q_cnt_d = q_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= 1'b0;
      q_rd_q  <= 1'b0;
      q_cnt_q <= 2'd0;
    end else begin
      q_wr_q  <= q_wr_d;
      q_rd_q  <= q_rd_d;
      q_cnt_q <= q_cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[q_wr_q] <= cmd_new;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= 2'(QDEPTH))
    else $error("command queue fill out of range");

  a_ptr_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt_q == 2'd1) |-> (q_wr_q != q_rd_q))
    else $error("queue pointers disagree with fill");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt_q == 2'd0) |=> (q_cnt_q <= 2'd1))
    else $error("queue fill jumped from empty");

endmodule

// ===== design/rfdc_back.sv =====
// rfdc_back: carries out commands on the ring, keeps pointers and drop counter, result register
// depends on rfdc_pkg and rfdc_ram
`timescale 1ns / 1ps

module rfdc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  rfdc_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rfdc_pkg::STAT_W-1:0] status_o,
  output logic [rfdc_pkg::DATA_W-1:0] event_out_o,
  output logic                        last_o,
  output logic [rfdc_pkg::DROP_W-1:0] drop_count_o
);
  import rfdc_pkg::*;

  localparam logic [PTR_W-1:0] PtrLast  = PTR_W'(2 * CAPACITY - 1);
  localparam logic [PTR_W-1:0] PtrHalf  = PTR_W'(CAPACITY);
  localparam logic [PTR_W:0]   PtrSpan  = (PTR_W + 1)'(2 * CAPACITY);
  localparam logic [DROP_W-1:0] DropMax = '1;

  bk_state_e              state_q, state_d;
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [DROP_W-1:0]      drop_q, drop_d;
  logic [CNT_W-1:0]       rem_q, rem_d;
  logic                   out_valid_q, out_valid_d;
  status_e                res_status_q, res_status_d;
  logic                   res_last_q, res_last_d;
  logic [DROP_W-1:0]      res_drop_q;
  logic                   issue;
  logic                   can_issue;
  logic [PTR_W-1:0]       level;
  logic [CNT_W-1:0]       level_c;
  logic [CNT_W-1:0]       take;
  logic                   full;
  logic                   ram_we;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_waddr;
  logic [IDX_W-1:0]       ram_raddr;
  logic [EVENT_WIDTH-1:0] ram_rdata;

  // fill level and slot indexes
  always_comb begin
    if (wr_ptr_q >= rd_ptr_q) begin
      level = wr_ptr_q - rd_ptr_q;
    end else begin
      level = PTR_W'(({1'b0, wr_ptr_q} + PtrSpan) - {1'b0, rd_ptr_q});
    end
    level_c   = CNT_W'(level);
    full      = (level == PtrHalf);
    take      = (cmd_i.count < level_c) ? cmd_i.count : level_c;
    ram_waddr = (wr_ptr_q >= PtrHalf) ? IDX_W'(wr_ptr_q - PtrHalf) : IDX_W'(wr_ptr_q);
    ram_raddr = (rd_ptr_q >= PtrHalf) ? IDX_W'(rd_ptr_q - PtrHalf) : IDX_W'(rd_ptr_q);
  end

  assign can_issue = !out_valid_q || out_ready_i;

  // sequencer: one result per step
  always_comb begin
    state_d      = state_q;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    drop_d       = drop_q;
    rem_d        = rem_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    issue        = 1'b0;
    cmd_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && can_issue) begin
          issue     = 1'b1;
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_WRITE: begin
              res_last_d = 1'b1;
              if (full) begin
                res_status_d = ST_DROPPED;
                if (drop_q != DropMax) begin
                  drop_d = drop_q + DROP_W'(1);
                end
              end else begin
                res_status_d = ST_WRITTEN;
                ram_we       = 1'b1;
                wr_ptr_d     = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PTR_W'(1);
              end
            end
            OP_READ: begin
              if (take == '0) begin
                res_status_d = ST_EMPTY;
                res_last_d   = 1'b1;
              end else begin
                res_status_d = ST_DELIVERED;
                res_last_d   = (take == CNT_W'(1));
                ram_re       = 1'b1;
                rd_ptr_d     = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PTR_W'(1);
                rem_d        = take - CNT_W'(1);
                if (take != CNT_W'(1)) begin
                  state_d = BK_BATCH;
                end
              end
            end
            default: begin
              res_last_d = 1'b1;
            end
          endcase
        end
      end
      BK_BATCH: begin
        if (can_issue) begin
          issue        = 1'b1;
          ram_re       = 1'b1;
          res_status_d = ST_DELIVERED;
          res_last_d   = (rem_q == CNT_W'(1));
          rd_ptr_d     = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PTR_W'(1);
          rem_d        = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    out_valid_d = issue ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      drop_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      drop_q      <= drop_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, event word comes from the ram read register
  always_ff @(posedge clk_i) begin
    if (issue) begin
      res_status_q <= res_status_d;
      res_last_q   <= res_last_d;
      res_drop_q   <= drop_d;
    end
  end

  rfdc_ram #(
    .Width (EVENT_WIDTH),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_status_q;
  assign last_o       = res_last_q;
  assign drop_count_o = res_drop_q;
  assign event_out_o  = (res_status_q == ST_DELIVERED) ? DATA_W'(ram_rdata) : '0;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= PtrHalf)
    else $error("ring fill above capacity");

  a_drop_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (drop_q >= $past(drop_q)))
    else $error("drop counter went backwards");

  a_batch_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_BATCH) |-> (rem_q != '0 && level != '0))
    else $error("batch running with nothing left");

  a_ram_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ring read and write in one step");

endmodule

// ===== design/ring_fifo_with_drop_count.sv =====
// ring_fifo_with_drop_count: top level of the event ring fifo with saturating drop counter
// depends on rfdc_pkg, rfdc_front, rfdc_back (which holds rfdc_ram)
//
//   channel | handshake                | payload
//   --------+--------------------------+----------------------------------------------
//   in      | in_valid_i / in_ready_o  | req_type_i, event_data_i, max_events_i
//   out     | out_valid_o / out_ready_i| status_o, event_out_o, last_o, drop_count_o
//
// writes and single reads go via the queue to the result register; one per cycle unless stalled
// a batch read gives one event per cycle unless stalled, rate set by the single ram read port
// a two-entry command queue lets requests be taken while the back end is busy or stalled
// out_ready_i low holds the result register and stops the back end; the queue then fills
// reset clears pointers, drop counter and queue; ring contents need no clearing
`timescale 1ns / 1ps

module ring_fifo_with_drop_count (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rfdc_pkg::REQ_W-1:0]  req_type_i,
  input  logic [rfdc_pkg::DATA_W-1:0] event_data_i,
  input  logic [rfdc_pkg::CNT_W-1:0]  max_events_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rfdc_pkg::STAT_W-1:0] status_o,
  output logic [rfdc_pkg::DATA_W-1:0] event_out_o,
  output logic                        last_o,
  output logic [rfdc_pkg::DROP_W-1:0] drop_count_o
);
  import rfdc_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: accept and classify items
  rfdc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .event_data_i (event_data_i),
    .max_events_i (max_events_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // back: ring access and results
  rfdc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .event_out_o  (event_out_o),
    .last_o       (last_o),
    .drop_count_o (drop_count_o)
  );

endmodule
